[hw/rtl/fsh_pkg.sv]
package fsh_pkg;

	localparam int SYMBOLS    = 256;
	localparam int COUNT_BITS = 48;

	localparam int SYM_BITS  = $clog2(SYMBOLS);
	localparam int DIST_BITS = $clog2(SYMBOLS + 1);

	// rank logic splits the presence flags into groups of GROUP symbols
	localparam int GROUP      = 32;
	localparam int GROUP_BITS = $clog2(GROUP);
	localparam int GROUPS     = (SYMBOLS + GROUP - 1) / GROUP;
	localparam int PAD        = GROUPS * GROUP;
	localparam int GCNT_BITS  = $clog2(GROUP + 1);
	localparam int CMP_BITS   = ((DIST_BITS > 8) ? DIST_BITS : 8) + 1;

	localparam int OUTQ_DEPTH    = 8;
	localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

	typedef logic [COUNT_BITS-1:0] count_t;

	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam count_t COUNT_ONE = count_t'(1);
	localparam logic [DIST_BITS-1:0] DIST_ONE = DIST_BITS'(1);
	localparam logic [OUTQ_PTR_BITS-1:0] OUTQ_LAST    = OUTQ_PTR_BITS'(OUTQ_DEPTH - 1);
	localparam logic [OUTQ_PTR_BITS-1:0] OUTQ_PTR_ONE = OUTQ_PTR_BITS'(1);
	localparam logic [OUTQ_CNT_BITS-1:0] OUTQ_CNT_ONE = OUTQ_CNT_BITS'(1);

	localparam logic [7:0] HEADER_MARK = 8'h3E;
	localparam logic [7:0] NEWLINE     = 8'h0A;

	typedef enum logic [1:0] {
		OP_DATA = 2'd0,
		OP_SYM  = 2'd1,
		OP_RANK = 2'd2
	} op_t;

	typedef struct packed {
		logic [7:0]  symbol;
		logic [7:0]  rank;
		logic        valid;
		logic [47:0] count;
		logic [47:0] length;
		logic [8:0]  distinct;
	} res_t;

	function automatic logic [47:0] field48(count_t c);
		logic [63:0] w;
		w = 64'(c);
		return w[47:0];
	endfunction

endpackage

[hw/rtl/fsh_ram.sv]
module fsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/fsh_outq.sv]
module fsh_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fsh_pkg::res_t push_data,
	output logic          out_valid,
	input  logic          out_ready,
	output fsh_pkg::res_t out_data
);

	fsh_pkg::res_t                      mem_q [fsh_pkg::OUTQ_DEPTH];
	logic [fsh_pkg::OUTQ_PTR_BITS-1:0]  wr_ptr_q;
	logic [fsh_pkg::OUTQ_PTR_BITS-1:0]  rd_ptr_q;
	logic [fsh_pkg::OUTQ_CNT_BITS-1:0]  cnt_q;
	logic                               pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// space is guaranteed by the credit check at the input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == fsh_pkg::OUTQ_LAST) ? '0
					: wr_ptr_q + fsh_pkg::OUTQ_PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == fsh_pkg::OUTQ_LAST) ? '0
					: rd_ptr_q + fsh_pkg::OUTQ_PTR_ONE;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + fsh_pkg::OUTQ_CNT_ONE;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - fsh_pkg::OUTQ_CNT_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/fasta_symbol_histogram_top.sv]
// Symbol histogram of a sequence-file byte stream with a dense rank map.
// Data bytes (header lines from '>' up to the newline skipped, newlines never
// counted) and symbol queries are taken one per cycle unless the input is held
// off: each count lives in a RAM with a registered read and is read, bumped and
// written back in the cycle after the byte, with the last write forwarded to a
// read of the same symbol. A rank query blocks the input while it searches: the
// symbol it finds is known only after the group search, and its count is then
// read on the query port of the second count RAM. Results pass through the query
// pipeline stages and leave through an 8-entry output queue; input is held off
// while the queue cannot take every query in flight. Presence flags are
// flip-flops cleared by reset and mask never-written count entries, so no
// clearing pass follows reset.
module fasta_symbol_histogram_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  query_rank,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_symbol,
	output logic [7:0]  out_rank,
	output logic        rank_valid,
	output logic [47:0] out_count,
	output logic [47:0] out_length,
	output logic [8:0]  out_distinct
);

	localparam int SB = fsh_pkg::SYM_BITS;
	localparam int DB = fsh_pkg::DIST_BITS;
	localparam int G  = fsh_pkg::GROUP;
	localparam int NG = fsh_pkg::GROUPS;
	localparam int CB = fsh_pkg::CMP_BITS;

	logic in_fire, is_data, is_sym, is_rank, sym_ok, hdr_eff, counted, first;
	logic [SB-1:0] sym_idx;

	// histogram state
	logic                        in_header_q;
	logic [fsh_pkg::SYMBOLS-1:0] present_q;
	fsh_pkg::count_t             length_q;
	logic [DB-1:0]               distinct_q;
	logic [fsh_pkg::OUTQ_CNT_BITS-1:0] occ_q;

	// count read-modify-write
	logic            wr_v_s1, wr_first_s1;
	logic [SB-1:0]   wr_sym_s1;
	logic            fwd_v_q;
	logic [SB-1:0]   fwd_sym_q;
	fsh_pkg::count_t fwd_cnt_q;
	fsh_pkg::count_t a_rdata, b_rdata, old_cnt, new_cnt;
	logic [SB-1:0]   b_raddr;

	// query pipeline
	logic [fsh_pkg::PAD-1:0]       pres_pad, below;
	logic [fsh_pkg::GCNT_BITS-1:0] gcnt_d [NG];

	logic                          q_v_s1, q_rank_s1, hit_s1;
	logic [7:0]                    sym_s1, qr_s1;
	fsh_pkg::count_t               len_s1;
	logic [DB-1:0]                 dist_s1;
	logic [fsh_pkg::GCNT_BITS-1:0] gcnt_s1 [NG];
	logic [fsh_pkg::PAD-1:0]       pres_s1;

	logic [CB-1:0]                  pre [NG+1];
	logic [NG-1:0]                  ghit;
	logic                           found;
	logic [7:0]                     base_d;
	logic [fsh_pkg::GROUP_BITS-1:0] loc_d;
	logic [G-1:0]                   gbits_d;
	fsh_pkg::count_t                cnt_sym;
	logic [CB-1:0]                  qr_w;

	logic                           q_v_s2, q_rank_s2, valid_s2;
	logic [7:0]                     sym_s2, rank_s2, base_s2;
	fsh_pkg::count_t                cnt_s2, len_s2;
	logic [DB-1:0]                  dist_s2;
	logic [fsh_pkg::GROUP_BITS-1:0] loc_s2;
	logic [G-1:0]                   gbits_s2;

	logic [7:0] jidx, rk_sym;
	logic       rank_rd;

	logic            q_v_s3, q_rank_s3, valid_s3;
	logic [7:0]      sym_s3, rank_s3;
	fsh_pkg::count_t cnt_s3, len_s3;
	logic [DB-1:0]   dist_s3;

	fsh_pkg::res_t res_d, oq_data;

	assign is_data = (opcode == fsh_pkg::OP_DATA);
	assign is_sym  = (opcode == fsh_pkg::OP_SYM);
	assign is_rank = (opcode == fsh_pkg::OP_RANK);
	assign in_fire = in_valid && in_ready;
	assign sym_ok  = int'(data_byte) < fsh_pkg::SYMBOLS;
	assign sym_idx = data_byte[SB-1:0];
	assign hdr_eff = start_of_file ? 1'b0 : in_header_q;
	assign counted = is_data && (data_byte != fsh_pkg::HEADER_MARK)
		&& (data_byte != fsh_pkg::NEWLINE) && !hdr_eff && sym_ok;
	assign first   = !present_q[sym_idx];

	// hold input while a rank query searches, or when the queue has no room
	assign in_ready = (int'(occ_q) < fsh_pkg::OUTQ_DEPTH)
		&& !(q_v_s1 && q_rank_s1) && !(q_v_s2 && q_rank_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b0;
			present_q   <= '0;
			length_q    <= '0;
			distinct_q  <= '0;
		end else if (in_fire && is_data) begin
			if (data_byte == fsh_pkg::HEADER_MARK) begin
				in_header_q <= 1'b1;
			end else if (data_byte == fsh_pkg::NEWLINE) begin
				in_header_q <= 1'b0;
			end else begin
				in_header_q <= hdr_eff;
			end
			if (counted) begin
				present_q[sym_idx] <= 1'b1;
				if (first) begin
					distinct_q <= distinct_q + fsh_pkg::DIST_ONE;
				end
				if (length_q != fsh_pkg::COUNT_MAX) begin
					length_q <= length_q + fsh_pkg::COUNT_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			if (in_fire && (is_sym || is_rank) && !(out_valid && out_ready)) begin
				occ_q <= occ_q + fsh_pkg::OUTQ_CNT_ONE;
			end else if (!(in_fire && (is_sym || is_rank)) && out_valid && out_ready) begin
				occ_q <= occ_q - fsh_pkg::OUTQ_CNT_ONE;
			end
		end
	end

	// count update: the previous write is forwarded, its RAM read came too early
	assign old_cnt = (fwd_v_q && (fwd_sym_q == wr_sym_s1)) ? fwd_cnt_q : a_rdata;
	assign new_cnt = wr_first_s1 ? fsh_pkg::COUNT_ONE
		: ((old_cnt == fsh_pkg::COUNT_MAX) ? old_cnt : old_cnt + fsh_pkg::COUNT_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			wr_v_s1 <= in_fire && counted;
			fwd_v_q <= wr_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		wr_sym_s1   <= sym_idx;
		wr_first_s1 <= first;
		fwd_sym_q   <= wr_sym_s1;
		fwd_cnt_q   <= new_cnt;
	end

	assign b_raddr = rank_rd ? rk_sym[SB-1:0] : sym_idx;

	fsh_ram #(
		.WIDTH (fsh_pkg::COUNT_BITS),
		.DEPTH (fsh_pkg::SYMBOLS)
	) u_cnt_ram_a (
		.clk   (clk),
		.we    (wr_v_s1),
		.waddr (wr_sym_s1),
		.wdata (new_cnt),
		.raddr (sym_idx),
		.rdata (a_rdata)
	);

	fsh_ram #(
		.WIDTH (fsh_pkg::COUNT_BITS),
		.DEPTH (fsh_pkg::SYMBOLS)
	) u_cnt_ram_b (
		.clk   (clk),
		.we    (wr_v_s1),
		.waddr (wr_sym_s1),
		.wdata (new_cnt),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// accept stage: per-group popcount of presence, masked below the symbol for a symbol query, unmasked for a rank query
	always_comb begin
		pres_pad = '0;
		pres_pad[fsh_pkg::SYMBOLS-1:0] = present_q;
		for (int i = 0; i < fsh_pkg::PAD; i++) begin
			below[i] = is_rank || (i < int'(data_byte));
		end
		for (int g = 0; g < NG; g++) begin
			gcnt_d[g] = fsh_pkg::GCNT_BITS'($countones(pres_pad[g*G +: G] & below[g*G +: G]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_v_s1    <= 1'b0;
			q_rank_s1 <= 1'b0;
			q_v_s2    <= 1'b0;
			q_rank_s2 <= 1'b0;
			q_v_s3    <= 1'b0;
			q_rank_s3 <= 1'b0;
		end else begin
			q_v_s1    <= in_fire && (is_sym || is_rank);
			q_rank_s1 <= in_fire && is_rank;
			q_v_s2    <= q_v_s1;
			q_rank_s2 <= q_v_s1 && q_rank_s1;
			q_v_s3    <= q_v_s2;
			q_rank_s3 <= q_v_s2 && q_rank_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sym_s1  <= data_byte;
			qr_s1   <= query_rank;
			hit_s1  <= sym_ok && present_q[sym_idx];
			len_s1  <= length_q;
			dist_s1 <= distinct_q;
			gcnt_s1 <= gcnt_d;
			pres_s1 <= pres_pad;
		end
	end

	// stage 1: group prefix sums, pick the group that holds the rank, select a symbol query's count
	always_comb begin
		qr_w   = CB'(qr_s1);
		pre[0] = '0;
		for (int g = 0; g < NG; g++) begin
			pre[g+1] = pre[g] + CB'(gcnt_s1[g]);
		end
		base_d  = '0;
		loc_d   = '0;
		gbits_d = '0;
		for (int g = 0; g < NG; g++) begin
			ghit[g] = (pre[g] <= qr_w) && (qr_w < pre[g+1]);
			if (ghit[g]) begin
				base_d  = base_d | 8'(g * G);
				loc_d   = loc_d | fsh_pkg::GROUP_BITS'(qr_w - pre[g]);
				gbits_d = gbits_d | pres_s1[g*G +: G];
			end
		end
		found = |ghit;
		if (!hit_s1) begin
			cnt_sym = '0;
		end else if (fwd_v_q && (fwd_sym_q == sym_s1[SB-1:0])) begin
			cnt_sym = fwd_cnt_q;
		end else begin
			cnt_sym = b_rdata;
		end
	end

	always_ff @(posedge clk) begin
		valid_s2 <= q_rank_s1 ? found : hit_s1;
		if (q_rank_s1) begin
			rank_s2 <= qr_s1;
		end else begin
			rank_s2 <= hit_s1 ? 8'(pre[NG]) : 8'd0;
		end
		sym_s2   <= sym_s1;
		cnt_s2   <= cnt_sym;
		len_s2   <= len_s1;
		dist_s2  <= dist_s1;
		base_s2  <= base_d;
		loc_s2   <= loc_d;
		gbits_s2 <= gbits_d;
	end

	// stage 2: find the set bit whose lower neighbors number the local rank
	always_comb begin
		jidx = '0;
		for (int j = 0; j < G; j++) begin
			if (gbits_s2[j] && (fsh_pkg::GROUP_BITS'($countones(gbits_s2 & ~({G{1'b1}} << j)))
				== loc_s2)) begin
				jidx = jidx | 8'(j);
			end
		end
		rk_sym = base_s2 | jidx;
	end

	assign rank_rd = q_v_s2 && q_rank_s2 && valid_s2;

	always_ff @(posedge clk) begin
		if (q_rank_s2) begin
			sym_s3 <= valid_s2 ? rk_sym : 8'd0;
		end else begin
			sym_s3 <= sym_s2;
		end
		rank_s3  <= rank_s2;
		valid_s3 <= valid_s2;
		cnt_s3   <= cnt_s2;
		len_s3   <= len_s2;
		dist_s3  <= dist_s2;
	end

	// stage 3: a rank query takes its count from the RAM read issued in stage 2
	always_comb begin
		res_d.symbol   = sym_s3;
		res_d.rank     = rank_s3;
		res_d.valid    = valid_s3;
		if (q_rank_s3) begin
			res_d.count = valid_s3 ? fsh_pkg::field48(b_rdata) : '0;
		end else begin
			res_d.count = fsh_pkg::field48(cnt_s3);
		end
		res_d.length   = fsh_pkg::field48(len_s3);
		res_d.distinct = 9'(dist_s3);
	end

	fsh_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_v_s3),
		.push_data (res_d),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (oq_data)
	);

	assign out_symbol   = oq_data.symbol;
	assign out_rank     = oq_data.rank;
	assign rank_valid   = oq_data.valid;
	assign out_count    = oq_data.count;
	assign out_length   = oq_data.length;
	assign out_distinct = oq_data.distinct;

endmodule

[hw/rtl/fsh_checker.sv]
module fsh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_symbol,
	input logic [7:0]  out_rank,
	input logic        rank_valid,
	input logic [47:0] out_count,
	input logic [47:0] out_length,
	input logic [8:0]  out_distinct
);

	// a rank query holds the input off while its search runs in stages 1 and 2
	a_rank_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (opcode == fsh_pkg::OP_RANK)) |=> !in_ready ##1 !in_ready)
		else $error("input taken during rank search");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_symbol)
			&& $stable(out_count) && $stable(out_length)))
		else $error("stalled result beat changed");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rank_valid) |-> (out_count == '0))
		else $error("count on an absent symbol or rank");

	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rank_valid) |-> ({1'b0, out_rank} < out_distinct))
		else $error("rank beyond distinct count");

	a_distinct_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(out_distinct) <= fsh_pkg::SYMBOLS))
		else $error("distinct count beyond alphabet");

endmodule

bind fasta_symbol_histogram_top fsh_checker u_fsh_checker (.*);

[sim/tb_fasta_symbol_histogram_top.sv]
`timescale 1ns / 1ps

module tb_fasta_symbol_histogram_top;

	localparam logic [1:0]  OP_NOP      = 2'd3; // unused opcode: no effect, no result
	localparam logic [47:0] SAT48       = '1;
	localparam int          CYCLE_LIMIT = 500000;
	localparam string       RESIDUES    = "ACGTNRYacgtn";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [7:0]  data_byte;
	logic [7:0]  query_rank;
	logic        start_of_file;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_symbol;
	logic [7:0]  out_rank;
	logic        rank_valid;
	logic [47:0] out_count;
	logic [47:0] out_length;
	logic [8:0]  out_distinct;

	// mirror of the histogram state
	bit          seen [256];
	logic [47:0] sym_count [256];
	logic [47:0] seq_length;
	logic [8:0]  n_distinct;
	bit          skipping_header;

	fsh_pkg::res_t pending_results [$];
	fsh_pkg::res_t want;
	int            errors;
	int            cycles;
	int            beats_sent;
	int            send_idle_pct;
	int            sink_stall_pct;

	fasta_symbol_histogram_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.data_byte     (data_byte),
		.query_rank    (query_rank),
		.start_of_file (start_of_file),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_symbol    (out_symbol),
		.out_rank      (out_rank),
		.rank_valid    (rank_valid),
		.out_count     (out_count),
		.out_length    (out_length),
		.out_distinct  (out_distinct)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [47:0] got,
	                               input logic [47:0] exp_val);
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, exp_val, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending, symbol", 48'(out_symbol), 48'd0);
			end else begin
				want = pending_results.pop_front();
				if (out_symbol !== want.symbol)
					report_mismatch("out_symbol", 48'(out_symbol), 48'(want.symbol));
				if (out_rank !== want.rank)
					report_mismatch("out_rank", 48'(out_rank), 48'(want.rank));
				if (rank_valid !== want.valid)
					report_mismatch("rank_valid", 48'(rank_valid), 48'(want.valid));
				if (out_count !== want.count)
					report_mismatch("out_count", out_count, want.count);
				if (out_length !== want.length)
					report_mismatch("out_length", out_length, want.length);
				if (out_distinct !== want.distinct)
					report_mismatch("out_distinct", 48'(out_distinct), 48'(want.distinct));
			end
		end
	end

	// apply one accepted beat to the mirror and queue the result it yields
	task automatic histogram_update(input logic [1:0] op, input logic [7:0] b,
	                                input logic [7:0] qr, input logic sof);
		fsh_pkg::res_t r;
		int            rank;
		bit            found;
		r     = '0;
		rank  = 0;
		found = 1'b0;
		case (op)
			fsh_pkg::OP_DATA: begin
				if (sof)
					skipping_header = 1'b0;
				if (b == fsh_pkg::HEADER_MARK) begin
					skipping_header = 1'b1;
				end else if (b == fsh_pkg::NEWLINE) begin
					skipping_header = 1'b0;
				end else if (!skipping_header) begin
					if (!seen[b]) begin
						seen[b]    = 1'b1;
						n_distinct = n_distinct + 9'd1;
					end
					if (sym_count[b] != SAT48)
						sym_count[b] = sym_count[b] + 48'd1;
					if (seq_length != SAT48)
						seq_length = seq_length + 48'd1;
				end
			end
			fsh_pkg::OP_SYM: begin
				r.symbol = b;
				if (seen[b]) begin
					for (int i = 0; i < int'(b); i++)
						if (seen[i])
							rank++;
					r.rank  = 8'(rank);
					r.valid = 1'b1;
					r.count = sym_count[b];
				end
				r.length   = seq_length;
				r.distinct = n_distinct;
				pending_results.push_back(r);
			end
			fsh_pkg::OP_RANK: begin
				r.rank = qr;
				for (int i = 0; i < 256; i++) begin
					if (seen[i]) begin
						if (rank == int'(qr) && !found) begin
							found    = 1'b1;
							r.symbol = 8'(i);
							r.count  = sym_count[i];
						end
						rank++;
					end
				end
				r.valid    = found;
				r.length   = seq_length;
				r.distinct = n_distinct;
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	// called at a falling edge with in_valid low; returns likewise
	task automatic send_beat(input logic [1:0] op, input logic [7:0] b,
	                         input logic [7:0] qr, input logic sof);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid      = 1'b1;
		opcode        = op;
		data_byte     = b;
		query_rank    = qr;
		start_of_file = sof;
		do @(posedge clk); while (!in_ready);
		histogram_update(op, b, qr, sof);
		beats_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_results_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_store();
		send_beat(fsh_pkg::OP_SYM, "A", 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_RANK, 8'd0, 8'd0, 1'b0);
		send_beat(OP_NOP, "A", 8'hFF, 1'b1);
	endtask

	task automatic test_header_filtering();
		send_beat(fsh_pkg::OP_DATA, fsh_pkg::HEADER_MARK, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_DATA, "Q", 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_DATA, fsh_pkg::NEWLINE, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_DATA, "A", 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_DATA, "C", 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_DATA, fsh_pkg::HEADER_MARK, 8'd0, 1'b0);
		// start of file ends the header before this byte is seen
		send_beat(fsh_pkg::OP_DATA, "Z", 8'd0, 1'b1);
		send_beat(fsh_pkg::OP_DATA, 8'h00, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_DATA, 8'hFF, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_DATA, "A", 8'd0, 1'b0);
	endtask

	task automatic test_queries_directed();
		send_beat(fsh_pkg::OP_SYM, "A", 8'd0, 1'b1);
		send_beat(fsh_pkg::OP_SYM, 8'h00, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_SYM, 8'hFF, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_SYM, fsh_pkg::HEADER_MARK, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_SYM, fsh_pkg::NEWLINE, 8'd0, 1'b0);
		send_beat(fsh_pkg::OP_RANK, 8'd0, 8'd4, 1'b0);
		send_beat(fsh_pkg::OP_RANK, 8'd0, 8'd5, 1'b1);
		send_beat(fsh_pkg::OP_RANK, 8'hFF, 8'd255, 1'b0);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
	                                   input int beats);
		int         first;
		int         kind;
		int         len;
		logic [7:0] b;
		logic [7:0] qr;
		first          = beats_sent;
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		while (beats_sent - first < beats) begin
			kind = $urandom_range(99);
			if (kind < 12) begin
				// header line with random content
				send_beat(fsh_pkg::OP_DATA, fsh_pkg::HEADER_MARK, 8'd0,
				          ($urandom_range(7) == 0));
				len = $urandom_range(6);
				for (int i = 0; i < len; i++)
					send_beat(fsh_pkg::OP_DATA, 8'($urandom_range(255)), 8'd0, 1'b0);
				send_beat(fsh_pkg::OP_DATA, fsh_pkg::NEWLINE, 8'd0, 1'b0);
			end else if (kind < 55) begin
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					send_beat(fsh_pkg::OP_DATA,
					          RESIDUES[$urandom_range(RESIDUES.len() - 1)],
					          8'($urandom_range(255)), ($urandom_range(15) == 0));
				if ($urandom_range(1))
					send_beat(fsh_pkg::OP_DATA, fsh_pkg::NEWLINE, 8'd0, 1'b0);
			end else if (kind < 65) begin
				send_beat(2'($urandom_range(3)), 8'($urandom_range(255)),
				          8'($urandom_range(255)), 1'($urandom_range(1)));
			end else if (kind < 85) begin
				if ($urandom_range(9) < 6)
					b = RESIDUES[$urandom_range(RESIDUES.len() - 1)];
				else
					b = 8'($urandom_range(255));
				send_beat(fsh_pkg::OP_SYM, b, 8'($urandom_range(255)),
				          1'($urandom_range(1)));
			end else begin
				if ($urandom_range(4) != 0)
					qr = 8'($urandom_range(int'(n_distinct) + 1));
				else
					qr = 8'($urandom_range(255));
				send_beat(fsh_pkg::OP_RANK, 8'($urandom_range(255)), qr,
				          1'($urandom_range(1)));
			end
		end
		wait_results_drained();
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		opcode          = fsh_pkg::OP_DATA;
		data_byte       = 8'd0;
		query_rank      = 8'd0;
		start_of_file   = 1'b0;
		errors          = 0;
		cycles          = 0;
		beats_sent      = 0;
		send_idle_pct   = 0;
		sink_stall_pct  = 0;
		skipping_header = 1'b0;
		seq_length      = '0;
		n_distinct      = '0;
		for (int i = 0; i < 256; i++) begin
			seen[i]      = 1'b0;
			sym_count[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_store();
		test_header_filtering();
		test_queries_directed();
		wait_results_drained();

		test_random_traffic(0, 0, 100);
		test_random_traffic(87, 0, 100);
		test_random_traffic(0, 87, 100);
		test_random_traffic(22, 22, 100);

		// let any late beat show up
		sink_stall_pct = 0;
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
